// ===== sv/trial_division_prime_counter_core_defines.svh =====
// Assertion macros used by the checker of the prime counter.
// No dependencies; the including module must provide clk and rst.
`ifndef TRIAL_DIVISION_PRIME_COUNTER_CORE_DEFINES_SVH
`define TRIAL_DIVISION_PRIME_COUNTER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TDPC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TDPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/tdpc_pkg.sv =====
// Package for the trial-division prime counter: widths and sequencer states.
// No dependencies.
package tdpc_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int COUNT_WIDTH = 32;
  localparam int BIT_CNT_WIDTH = $clog2(VALUE_WIDTH);

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [BIT_CNT_WIDTH-1:0] bit_cnt_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_CHECK,
    ST_DONE
  } state_t;

endpackage

// ===== sv/trial_division_prime_counter_core.sv =====
// Trial-division prime tester with a saturating prime count.
// Depends on tdpc_pkg.
//
// Usage: candidates enter on in_valid/in_ready, one item each, and each item
// produces exactly one result item on out_valid/out_ready carrying is_prime,
// in_range and the running prime_count. The user must write upper_limit with
// upper_limit_we only while the block is idle; the block does not enforce it.
// Candidates above the limit are not tested and not counted.
// Flow: out-of-range, small and even candidates go from idle straight to the
// done state without division. Odd candidates are divided by 3, 5, 7 and up
// with a restoring divider that produces one quotient bit per cycle; the test
// stops once the divisor exceeds the quotient or a trial remainder is zero.
// A large prime near 2^32 takes about 32768 divisors. One item is processed
// at a time; in_ready is high while the sequencer is idle, even when a result
// still waits.
// Stall: a finished result waits in the output register; a second finished
// result holds in the sequencer until the first is taken.
// Reset: rst (synchronous) clears the count to zero, sets upper_limit to all
// ones, and drops out_valid.
module trial_division_prime_counter_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  tdpc_pkg::value_t    candidate,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                is_prime,
  output logic                in_range,
  output tdpc_pkg::count_t    prime_count,
  input  logic                upper_limit_we,
  input  tdpc_pkg::value_t    upper_limit
);
  import tdpc_pkg::*;

  localparam bit_cnt_t LAST_BIT = bit_cnt_t'(VALUE_WIDTH - 1);
  localparam count_t COUNT_MAX = '1;

  state_t state, state_next;
  value_t limit;
  value_t num;
  value_t divisor;
  value_t rem;
  value_t quo;
  bit_cnt_t bit_cnt;
  logic range_ok;
  logic prime;
  count_t total;

  logic in_accept;
  logic load_out;
  logic cand_within;
  logic cand_trivial;
  logic cand_trivial_prime;
  logic [VALUE_WIDTH:0] shifted;
  logic [VALUE_WIDTH+1:0] diff;
  logic fits;
  logic bound_hit;
  logic rem_zero;

  assign in_accept = in_valid && in_ready;
  assign cand_within = candidate <= limit;
  assign cand_trivial = !cand_within || (candidate <= value_t'(2)) || !candidate[0];
  assign cand_trivial_prime = cand_within && (candidate == value_t'(2));

  assign shifted = {rem, quo[VALUE_WIDTH-1]};
  assign diff = {1'b0, shifted} - {2'b00, divisor};
  assign fits = !diff[VALUE_WIDTH+1];
  assign bound_hit = divisor > quo;
  assign rem_zero = rem == '0;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = cand_trivial ? ST_DONE : ST_DIV;
        end
      end
      ST_DIV: begin
        if (bit_cnt == LAST_BIT) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (bound_hit || rem_zero) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_DIV;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = state == ST_IDLE;
    load_out = (state == ST_DONE) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      limit <= '1;
      total <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (upper_limit_we) begin
        limit <= upper_limit;
      end
      if (load_out) begin
        out_valid <= 1'b1;
        if (prime && total != COUNT_MAX) begin
          total <= total + count_t'(1);
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          num <= candidate;
          range_ok <= cand_within;
          prime <= cand_trivial_prime;
          divisor <= value_t'(3);
          quo <= candidate;
          rem <= '0;
          bit_cnt <= '0;
        end
      end
      ST_DIV: begin
        rem <= fits ? diff[VALUE_WIDTH-1:0] : shifted[VALUE_WIDTH-1:0];
        quo <= {quo[VALUE_WIDTH-2:0], fits};
        bit_cnt <= bit_cnt + bit_cnt_t'(1);
      end
      ST_CHECK: begin
        prime <= bound_hit;
        divisor <= divisor + value_t'(2);
        quo <= num;
        rem <= '0;
        bit_cnt <= '0;
      end
      default: begin
      end
    endcase
    if (load_out) begin
      is_prime <= prime;
      in_range <= range_ok;
      prime_count <= (prime && total != COUNT_MAX) ? total + count_t'(1) : total;
    end
  end

endmodule

// ===== sv/tdpc_checker.sv =====
// Port-level checks for the prime counter, bound to its top level.
// Depends on tdpc_pkg and trial_division_prime_counter_core_defines.svh.
`include "trial_division_prime_counter_core_defines.svh"

module tdpc_checker (
  input logic             clk,
  input logic             rst,
  input logic             out_valid,
  input logic             out_ready,
  input logic             is_prime,
  input logic             in_range,
  input tdpc_pkg::count_t prime_count
);
  import tdpc_pkg::*;

  `TDPC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(prime_count), "Stalled result item changed or dropped.")
  `TDPC_ASSERT_IMP(a_prime_in_range, out_valid && is_prime, in_range, "Prime reported for an out-of-range item.")
  `TDPC_ASSERT_IMP(a_prime_counted, out_valid && is_prime, prime_count != '0, "Prime reported with a zero count.")
  `TDPC_ASSERT_NEXT(a_count_monotonic, out_valid, prime_count >= $past(prime_count), "Prime count decreased.")

endmodule

bind trial_division_prime_counter_core tdpc_checker u_tdpc_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .is_prime    (is_prime),
  .in_range    (in_range),
  .prime_count (prime_count)
);
